FILE: hw/rtl/signed_integer_to_decimal_ascii_core_defines.svh
// Assertion macros used by the checker file of the decimal text converter.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SITDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sitda_pkg.sv
// Shared constants and types of the decimal text converter.
`default_nettype none

package sitda_pkg;

  localparam int VALUE_W        = 64;
  localparam int CHAR_W         = 6;
  localparam int VALUE_BITS     = 64;
  localparam int MAX_DIGITS     = 19;
  localparam int BITS_PER_STAGE = 8;
  localparam int NUM_STAGES     = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int MAG_W          = NUM_STAGES * BITS_PER_STAGE;
  localparam int BCD_W          = 4 * MAX_DIGITS;
  localparam int CNT_W          = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W          = $clog2(MAX_DIGITS);

  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CH_NINE  = CHAR_W'(57);

  localparam logic [3:0] DIGIT_FIVE = 4'd5;
  localparam logic [3:0] DIGIT_ADJ  = 4'd3;

  typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

  // Item in flight through the conversion stages.
  typedef struct packed {
    logic             neg;
    logic             ovf;
    bcd_t             bcd;
    logic [MAG_W-1:0] mag;
  } dd_t;

  // Converted number ready for the character stream.
  typedef struct packed {
    logic             neg;
    bcd_t             bcd;
    logic [CNT_W-1:0] cnt;
  } num_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sitda_dabble_stage.sv
// One registered shift-and-add-three stage of the binary to BCD conversion.
`default_nettype none

module sitda_dabble_stage
  import sitda_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  dd_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output dd_t  dn_data
);

  logic valid_r;
  dd_t  data_r;
  dd_t  data_nxt;

  always_comb begin
    logic [BCD_W:0] flat;
    data_nxt = up_data;
    flat     = '0;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (data_nxt.bcd[d] >= DIGIT_FIVE) begin
          data_nxt.bcd[d] = data_nxt.bcd[d] + DIGIT_ADJ;
        end
      end
      // a carry out of the top digit means the lowest digits are all we keep
      data_nxt.ovf = data_nxt.ovf | data_nxt.bcd[MAX_DIGITS-1][3];
      flat         = {data_nxt.bcd, data_nxt.mag[MAG_W-1]};
      data_nxt.bcd = flat[BCD_W-1:0];
      data_nxt.mag = {data_nxt.mag[MAG_W-2:0], 1'b0};
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sitda_count_stage.sv
// Registered stage that finds how many digits a converted number shows.
`default_nettype none

module sitda_count_stage
  import sitda_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  dd_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output num_t dn_data
);

  logic valid_r;
  num_t data_r;
  num_t data_nxt;

  always_comb begin
    data_nxt.neg = up_data.neg;
    data_nxt.bcd = up_data.bcd;
    data_nxt.cnt = CNT_W'(1);
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (up_data.bcd[i] != 4'd0) begin
        data_nxt.cnt = CNT_W'(i + 1);
      end
    end
    // truncated: every kept digit is shown, leading zeros too
    if (up_data.ovf) begin
      data_nxt.cnt = CNT_W'(MAX_DIGITS);
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sitda_emitter.sv
// Character sequencer: holds one number and streams its text through an output register.
`default_nettype none

module sitda_emitter
  import sitda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  num_t              up_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  bcd_t              digits_r;
  logic [CNT_W-1:0]  left_r;
  logic [CNT_W-1:0]  left_nxt;
  logic              sign_r;
  logic              sign_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic              busy;
  logic              out_free;
  logic              fire;
  logic              done;
  logic              load;
  logic [CNT_W-1:0]  left_m1;
  logic [IDX_W-1:0]  idx;
  logic [3:0]        digit;
  logic [CHAR_W-1:0] char_nxt;
  logic              last_nxt;

  assign busy     = sign_r || (left_r != '0);
  assign out_free = !out_valid_r || out_ready;
  assign fire     = busy && out_free;
  assign left_m1  = left_r - CNT_W'(1);
  assign idx      = left_m1[IDX_W-1:0];
  assign digit    = digits_r[idx];

  always_comb begin
    if (sign_r) begin
      char_nxt = CH_MINUS;
      last_nxt = 1'b0;
      sign_nxt = 1'b0;
      left_nxt = left_r;
    end else begin
      char_nxt = CH_ZERO + CHAR_W'(digit);
      last_nxt = (left_r == CNT_W'(1));
      sign_nxt = 1'b0;
      left_nxt = left_m1;
    end
  end

  // take the next number while idle or in the cycle that sends the last character
  assign done     = !busy || (fire && last_nxt);
  assign load     = up_valid && done;
  assign up_ready = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        sign_r <= up_data.neg;
        left_r <= up_data.cnt;
      end else if (fire) begin
        sign_r <= sign_nxt;
        left_r <= left_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= up_data.bcd;
    end
    if (fire) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/signed_integer_to_decimal_ascii_core.sv
// Path: entry register, dabble stages, count stage, emitter, output register. Numbers enter the
// pipe every cycle unless it stalls. Throughput: one character per cycle while out_ready is high,
// set by the single output register; a number is 1 to 20 characters (digits plus minus sign).
// Reset: rst_n (synchronous, active low) empties every stage and the output register;
// digit payloads are not cleared.
`default_nettype none

module signed_integer_to_decimal_ascii_core
  import sitda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_character,
  output logic                out_last
);

  // Entry stage: keep the low VALUE_BITS bits, take the sign and form an unsigned
  // magnitude. Treating the magnitude as unsigned converts the most negative value
  // correctly, since 2^(VALUE_BITS-1) still fits in VALUE_BITS bits.
  logic [VALUE_BITS-1:0] raw;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag_abs;
  dd_t                   entry_nxt;
  dd_t                   entry_r;
  logic                  entry_valid_r;

  assign raw     = in_value[VALUE_BITS-1:0];
  assign neg     = raw[VALUE_BITS-1];
  assign mag_abs = neg ? (VALUE_BITS'(0) - raw) : raw;

  always_comb begin
    entry_nxt.neg = neg;
    entry_nxt.ovf = 1'b0;
    entry_nxt.bcd = '0;
    entry_nxt.mag = MAG_W'(mag_abs);
  end

  // Conversion pipe: the magnitude is shifted into a BCD register, BITS_PER_STAGE
  // bits per stage. Each stage holds its own valid bit and stalls only when the
  // stage below is full and not advancing.
  logic              ch_valid [NUM_STAGES+1];
  logic              ch_ready [NUM_STAGES+1];
  dd_t               ch_data  [NUM_STAGES+1];

  assign in_ready    = !entry_valid_r || ch_ready[0];
  assign ch_valid[0] = entry_valid_r;
  assign ch_data[0]  = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else if (in_ready) begin
      entry_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry_r <= entry_nxt;
    end
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    sitda_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[g]),
      .up_ready (ch_ready[g]),
      .up_data  (ch_data[g]),
      .dn_valid (ch_valid[g+1]),
      .dn_ready (ch_ready[g+1]),
      .dn_data  (ch_data[g+1])
    );
  end

  // Digit count: find the most significant non-zero digit; zero shows one digit.
  logic num_valid;
  logic num_ready;
  num_t num_data;

  sitda_count_stage u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ch_valid[NUM_STAGES]),
    .up_ready (ch_ready[NUM_STAGES]),
    .up_data  (ch_data[NUM_STAGES]),
    .dn_valid (num_valid),
    .dn_ready (num_ready),
    .dn_data  (num_data)
  );

  // Character stream: minus sign first where negative, then digits most significant
  // first, last marked on the final digit. The output register lets the pipe keep
  // filling while a character waits for its transfer.
  sitda_emitter u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (num_valid),
    .up_ready      (num_ready),
    .up_data       (num_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sitda_checker.sv
// Port-level checker for the decimal text converter, with its bind.
`default_nettype none
`include "signed_integer_to_decimal_ascii_core_defines.svh"

module sitda_checker
  import sitda_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last
);

  logic is_minus;
  logic is_digit;
  logic out_xfer;

  assign is_minus = (out_character == CH_MINUS);
  assign is_digit = (out_character >= CH_ZERO) && (out_character <= CH_NINE);
  assign out_xfer = out_valid && out_ready;

  `SITDA_ASSERT_NOW(a_char_legal, out_valid, is_minus || is_digit, "illegal character code")
  `SITDA_ASSERT_NOW(a_minus_not_last, out_valid && is_minus, !out_last, "minus marked last")
  `SITDA_ASSERT_NEXT(a_no_gap, out_xfer && !out_last, out_valid, "gap inside a number")
  `SITDA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_character) && $stable(out_last), "stalled output changed")

endmodule

bind signed_integer_to_decimal_ascii_core sitda_checker u_checker (.*);

`default_nettype wire

FILE: dv/signed_integer_to_decimal_ascii_core_test.sv
// Testbench for the signed integer to decimal text converter, with its own prediction of the text.
`default_nettype none

module signed_integer_to_decimal_ascii_core_test
  import sitda_pkg::*;
();

  // One expected character of the decimal text.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // Longest stretch without any transfer before the run is declared hung. It covers
  // the deliberate receiver hold-off below with plenty of margin.
  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 500;
  // Extra wait after the last expected character, so stray characters can surface.
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_VALUES   = 310;
  localparam int REPORT_LIMIT    = 10;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [VALUE_W-1:0]  in_value  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAR_W-1:0]   out_character;
  logic                out_last;

  logic [VALUE_W-1:0]  pending_values [$];
  text_char_t          text_due [$];
  int                  item_total    = 0;
  int                  values_sent   = 0;
  int                  mismatches    = 0;
  int                  hold_off_left = 0;
  bit                  hold_off_done = 1'b0;
  int                  quiet_cycles  = 0;
  bit                  timed_out     = 1'b0;

  signed_integer_to_decimal_ascii_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the text of one value and queue its characters, most significant first.
  // The magnitude is taken as unsigned, so the most negative value needs no special path.
  task automatic expect_decimal_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits [MAX_DIGITS];
    logic               neg;
    int                 count;
    mask  = (VALUE_BITS >= VALUE_W) ? '1 : ((VALUE_W'(1) << VALUE_BITS) - 1'b1);
    raw   = value & mask;
    neg   = raw[VALUE_BITS-1];
    mag   = neg ? ((-raw) & mask) : raw;
    // At least one digit, so zero gives a lone '0'; keep only the low MAX_DIGITS digits.
    digits[0] = 4'(mag % 10);
    mag       = mag / 10;
    count     = 1;
    while (mag != 0 && count < MAX_DIGITS) begin
      digits[count] = 4'(mag % 10);
      mag           = mag / 10;
      count++;
    end
    if (neg)
      text_due.push_back('{code: CH_MINUS, last: 1'b0});
    for (int i = count - 1; i >= 0; i--)
      text_due.push_back('{code: CH_ZERO + CHAR_W'(digits[i]), last: (i == 0)});
  endtask

  // Idle percentage for each side: first the sender idles less than the receiver,
  // then the other way round, and the last third runs flat out.
  function automatic int idle_pct(input bit receiver);
    if (values_sent < item_total / 3)
      return receiver ? 72 : 32;
    else if (values_sent < (2 * item_total) / 3)
      return receiver ? 32 : 72;
    else
      return 0;
  endfunction

  // Random value with a spread of digit counts: full width, short widths, bounded
  // decimal lengths and neighbours of powers of ten, each with either sign.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] tens;
    int unsigned        kind;
    v    = {$urandom, $urandom};
    tens = VALUE_W'(1);
    kind = $urandom_range(3);
    if (kind != 0) begin
      repeat ($urandom_range(1, 18)) tens = tens * 10;
      case (kind)
        1:       v = v >> $urandom_range(VALUE_W - 1);
        2:       v = v % tens;
        default: v = tens + $urandom_range(2) - 1;
      endcase
      if ($urandom_range(1))
        v = -v;
    end
    return v;
  endfunction

  // Driver: offer the next value whenever the slot is free; hold the payload while
  // the block stalls. The prediction is made on the transfer itself.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expect_decimal_text(in_value);
        values_sent <= values_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off during the flat-out phase, so the pipe fills and the
  // input side has to stall while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off_left <= 0;
    end else if (!hold_off_done && values_sent == (3 * item_total) / 4) begin
      hold_off_left <= HOLD_OFF_CYCLES;
      hold_off_done <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Monitor: compare each character transfer with the oldest expected character.
  always @(posedge clk) begin : take_text
    text_char_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (text_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected character %0d last %0b, nothing due",
                     $time, out_character, out_last);
        end else begin
          due = text_due.pop_front();
          if (out_character !== due.code || out_last !== due.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: character mismatch: expected %0d last %0b, got %0d last %0b",
                       $time, due.code, due.last, out_character, out_last);
          end
        end
      end
      out_ready <= (hold_off_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Watchdog: flag the run as hung after too long without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (!timed_out) begin
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d values sent, %0d characters due",
                 $time, QUIET_LIMIT, values_sent, text_due.size());
        timed_out <= 1'b1;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Directed values: zero, single digits, carries across powers of ten, the widest
    // positive and negative magnitudes, and the most negative value itself.
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(-64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(-64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd99);
    pending_values.push_back(-64'd100);
    pending_values.push_back(64'd1234567890);
    pending_values.push_back(-64'd9876543210);
    pending_values.push_back(64'd999999999999999999);
    pending_values.push_back(64'd1000000000000000000);
    pending_values.push_back(-64'd1000000000000000000);
    pending_values.push_back(64'd1000000000000000001);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h8000_0000_0000_0001);
    pending_values.push_back(64'hFFFF_FFFF_0000_0000);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    for (int i = 0; i < RANDOM_VALUES; i++)
      pending_values.push_back(pick_value());
    item_total = pending_values.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every value to be taken and every character to come back.
    while (!(timed_out || (values_sent == item_total && text_due.size() == 0)))
      @(posedge clk);
    // Let any stray characters surface before the verdict.
    if (!timed_out)
      repeat (DRAIN_CYCLES) @(posedge clk);

    if (timed_out || mismatches != 0 || text_due.size() != 0)
      $display("== FAIL ==");
    else
      $display("== PASS ==");
    $finish;
  end

endmodule

`default_nettype wire
